[rtl/bpc_pkg.sv]
// Package: payload types, register indexes and constants for the pressure compensation unit.
`default_nettype none
package bpc_pkg;

   localparam int unsigned DIV_STAGES = 32;
   localparam int unsigned UP_WIDTH   = 19;

   localparam logic [2:0] REG_AC1_AC2 = 3'd0;
   localparam logic [2:0] REG_AC3_AC4 = 3'd1;
   localparam logic [2:0] REG_AC5_AC6 = 3'd2;
   localparam logic [2:0] REG_B1_B2   = 3'd3;
   localparam logic [2:0] REG_MC_MD   = 3'd4;
   localparam logic [2:0] REG_OSS     = 3'd5;

   localparam logic [31:0] B6_OFFSET   = 32'd4000;
   localparam logic [31:0] C_3038      = 32'd3038;
   localparam logic [31:0] C_NEG_7357  = 32'hFFFF_E343;
   localparam logic [31:0] C_3791      = 32'd3791;
   localparam logic [15:0] B7_SCALE    = 16'd50000;
   localparam logic [31:0] B4_OFFSET   = 32'd32768;
   localparam logic [17:0] PRESS_MAX   = 18'h3FFFF;

   typedef struct packed {
      logic [7:0] temp_high_byte;
      logic [7:0] temp_low_byte;
      logic [7:0] press_high_byte;
      logic [7:0] press_mid_byte;
      logic [7:0] press_extra_byte;
   } req_type;

   typedef struct packed {
      logic signed [15:0] temperature_tenths;
      logic [17:0]        pressure_pa;
      logic               divide_fault;
   } rsp_type;

   // travels beside a divider pipeline
   typedef struct packed {
      logic                  valid;
      logic                  fault;
      logic                  neg;
      logic                  big;
      logic [31:0]           x1;
      logic [UP_WIDTH-1:0]   up;
      logic [15:0]           temp;
   } side_type;

   function automatic logic [31:0] sx16(input logic [15:0] h);
      sx16 = {{16{h[15]}}, h};
   endfunction

endpackage
`default_nettype wire

[rtl/barometric_pressure_compensation_unit.sv]
// Top level: barometric sensor integer compensation, deep pipeline with two pipelined dividers.
`default_nettype none
// Takes one raw reading (two temperature bytes, three pressure bytes) per transaction
// and returns one compensated result: temperature in 0.1 degC, pressure in Pa, and a
// fault flag that is set (with both values zero) when either divisor of the scheme is
// zero. A new transaction is accepted every cycle in which the pipe advances, through two
// 32-stage restoring dividers plus twelve arithmetic stages. The whole pipe advances
// whenever the output register is empty or being taken, so a stall on rsp_ holds every
// stage and drives req_stall. Calibration words and the oversampling setting are to be
// written through csr_ only while no transaction is in flight; the block does not check.
module barometric_pressure_compensation_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire bpc_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output bpc_pkg::rsp_type       rsp_data,
   input  wire logic              csr_write_enable,
   input  wire logic [2:0]        csr_index,
   input  wire logic [31:0]       csr_wdata
);

   // ---------------- configuration ----------------
   logic [31:0] ac1_ac2_ff, ac3_ac4_ff, ac5_ac6_ff, b1_b2_ff, mc_md_ff;
   logic [1:0]  oss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ac1_ac2_ff <= '0;
         ac3_ac4_ff <= '0;
         ac5_ac6_ff <= '0;
         b1_b2_ff   <= '0;
         mc_md_ff   <= '0;
         oss_ff     <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bpc_pkg::REG_AC1_AC2: ac1_ac2_ff <= csr_wdata;
            bpc_pkg::REG_AC3_AC4: ac3_ac4_ff <= csr_wdata;
            bpc_pkg::REG_AC5_AC6: ac5_ac6_ff <= csr_wdata;
            bpc_pkg::REG_B1_B2:   b1_b2_ff   <= csr_wdata;
            bpc_pkg::REG_MC_MD:   mc_md_ff   <= csr_wdata;
            bpc_pkg::REG_OSS:     oss_ff     <= csr_wdata[1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = bpc_pkg::sx16(ac1_ac2_ff[31:16]);
   assign ac2 = bpc_pkg::sx16(ac1_ac2_ff[15:0]);
   assign ac3 = bpc_pkg::sx16(ac3_ac4_ff[31:16]);
   assign ac4 = {16'd0, ac3_ac4_ff[15:0]};
   assign ac5 = {16'd0, ac5_ac6_ff[31:16]};
   assign ac6 = {16'd0, ac5_ac6_ff[15:0]};
   assign b1  = bpc_pkg::sx16(b1_b2_ff[31:16]);
   assign b2  = bpc_pkg::sx16(b1_b2_ff[15:0]);
   assign mc  = bpc_pkg::sx16(mc_md_ff[31:16]);
   assign md  = bpc_pkg::sx16(mc_md_ff[15:0]);

   // ---------------- flow control ----------------
   // advance everything unless a finished result is waiting and stalled
   logic advance;
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // ---------------- stage 1: assemble raw values ----------------
   logic                          s1_valid_ff;
   logic [15:0]                   s1_ut_ff;
   logic [bpc_pkg::UP_WIDTH-1:0]  s1_up_ff;
   logic [23:0]                   raw_press;
   logic [23:0]                   up_shift;

   assign raw_press = {req_data.press_high_byte, req_data.press_mid_byte,
                       req_data.press_extra_byte};
   assign up_shift  = raw_press >> (4'd8 - {2'b00, oss_ff});

   // ---------------- stage 2: X1 ----------------
   logic                          s2_valid_ff;
   logic [31:0]                   s2_x1_ff;
   logic [bpc_pkg::UP_WIDTH-1:0]  s2_up_ff;
   logic [31:0]                   s2_prod;

   assign s2_prod = ({16'd0, s1_ut_ff} - ac6) * ac5;

   // ---------------- divider A: MC<<11 / (X1+MD) ----------------
   logic [31:0]       da_x2, da_num, da_an, da_ad, da_q;
   bpc_pkg::side_type da_side, da_out;

   always_comb begin
      da_x2  = s2_x1_ff + md;
      da_num = mc << 11;
      da_an  = da_num[31] ? (32'd0 - da_num) : da_num;
      da_ad  = da_x2[31] ? (32'd0 - da_x2) : da_x2;
      da_side       = '0;
      da_side.valid = s2_valid_ff;
      da_side.fault = (da_x2 == 32'd0);
      da_side.neg   = da_num[31] ^ da_x2[31];
      da_side.x1    = s2_x1_ff;
      da_side.up    = s2_up_ff;
      if (da_x2 == 32'd0) begin
         da_ad = 32'd1;
      end
   end

   bpc_div u_div_temp (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .num      (da_an),
      .den      (da_ad),
      .side     (da_side),
      .quotient (da_q),
      .side_out (da_out)
   );

   // ---------------- stage 4: B5, temperature, B6 ----------------
   logic                          s4_valid_ff, s4_fault_ff;
   logic [bpc_pkg::UP_WIDTH-1:0]  s4_up_ff;
   logic [15:0]                   s4_temp_ff;
   logic [31:0]                   s4_b6_ff;
   logic [31:0]                   s4_b5, s4_t;
   logic [15:0]                   s4_temp_sat;

   always_comb begin
      s4_b5 = da_out.x1 + (da_out.neg ? (32'd0 - da_q) : da_q);
      s4_t  = 32'($signed(s4_b5 + 32'd8) >>> 4);
      if ($signed(s4_t) < -32'sd32768) begin
         s4_temp_sat = 16'h8000;
      end else if ($signed(s4_t) > 32'sd32767) begin
         s4_temp_sat = 16'h7FFF;
      end else begin
         s4_temp_sat = s4_t[15:0];
      end
   end

   // ---------------- stage 5: B6 products ----------------
   logic                          s5_valid_ff, s5_fault_ff;
   logic [bpc_pkg::UP_WIDTH-1:0]  s5_up_ff;
   logic [15:0]                   s5_temp_ff;
   logic [31:0]                   s5_b6sq_ff, s5_x2a_ff, s5_x1b_ff;
   logic [31:0]                   s5_sq, s5_p2, s5_p3;

   assign s5_sq = s4_b6_ff * s4_b6_ff;
   assign s5_p2 = ac2 * s4_b6_ff;
   assign s5_p3 = ac3 * s4_b6_ff;

   // ---------------- stage 6: B6SQ products ----------------
   logic                          s6_valid_ff, s6_fault_ff;
   logic [bpc_pkg::UP_WIDTH-1:0]  s6_up_ff;
   logic [15:0]                   s6_temp_ff;
   logic [31:0]                   s6_x1a_ff, s6_x2a_ff, s6_x1b_ff, s6_x2b_ff;
   logic [31:0]                   s6_pa, s6_pb;

   assign s6_pa = b2 * s5_b6sq_ff;
   assign s6_pb = b1 * s5_b6sq_ff;

   // ---------------- stage 7: B3 and X3 ----------------
   logic                          s7_valid_ff, s7_fault_ff;
   logic [bpc_pkg::UP_WIDTH-1:0]  s7_up_ff;
   logic [15:0]                   s7_temp_ff;
   logic [31:0]                   s7_b3_ff, s7_x3_ff;
   logic [31:0]                   s7_sum;

   assign s7_sum = ((ac1 << 2) + s6_x1a_ff + s6_x2a_ff) << oss_ff;

   // ---------------- stage 8: B4 and UP-B3 ----------------
   logic                          s8_valid_ff, s8_fault_ff;
   logic [15:0]                   s8_temp_ff;
   logic [31:0]                   s8_b4_ff, s8_diff_ff;
   logic [31:0]                   s8_b4p;

   assign s8_b4p = ac4 * (s7_x3_ff + bpc_pkg::B4_OFFSET);

   // ---------------- stage 9: B7 ----------------
   logic                          s9_valid_ff, s9_fault_ff;
   logic [15:0]                   s9_temp_ff;
   logic [31:0]                   s9_b7_ff, s9_b4_ff;
   logic [31:0]                   s9_b7;

   assign s9_b7 = s8_diff_ff * {16'd0, 16'(bpc_pkg::B7_SCALE >> oss_ff)};

   // ---------------- divider B: pressure ----------------
   logic [31:0]       db_q;
   bpc_pkg::side_type db_side, db_out;

   always_comb begin
      db_side       = '0;
      db_side.valid = s9_valid_ff;
      db_side.fault = s9_fault_ff || (s9_b4_ff == 32'd0);
      db_side.big   = s9_b7_ff[31];
      db_side.temp  = s9_temp_ff;
   end

   bpc_div u_div_press (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .num      (s9_b7_ff[31] ? s9_b7_ff : (s9_b7_ff << 1)),
      .den      ((s9_b4_ff == 32'd0) ? 32'd1 : s9_b4_ff),
      .side     (db_side),
      .quotient (db_q),
      .side_out (db_out)
   );

   // ---------------- stage 10: p ----------------
   logic        s10_valid_ff, s10_fault_ff;
   logic [15:0] s10_temp_ff;
   logic [31:0] s10_p_ff;

   // ---------------- stage 11: p products ----------------
   logic        s11_valid_ff, s11_fault_ff;
   logic [15:0] s11_temp_ff;
   logic [31:0] s11_p_ff, s11_sq_ff, s11_x2_ff;
   logic [31:0] s11_ps, s11_x2p;

   assign s11_ps  = 32'($signed(s10_p_ff) >>> 8);
   assign s11_x2p = bpc_pkg::C_NEG_7357 * s10_p_ff;

   // ---------------- stage 12: X1 ----------------
   logic        s12_valid_ff, s12_fault_ff;
   logic [15:0] s12_temp_ff;
   logic [31:0] s12_p_ff, s12_x1_ff, s12_x2_ff;
   logic [31:0] s12_prod;

   assign s12_prod = s11_sq_ff * bpc_pkg::C_3038;

   // ---------------- stage 13: final pressure, output register ----------------
   bpc_pkg::rsp_type rsp_data_ff;
   bpc_pkg::rsp_type rsp_data_in;
   logic [31:0]      fin_p;

   always_comb begin
      fin_p = s12_p_ff + 32'($signed(s12_x1_ff + s12_x2_ff + bpc_pkg::C_3791) >>> 4);
      rsp_data_in = '0;
      if (s12_fault_ff) begin
         rsp_data_in.divide_fault = 1'b1;
      end else begin
         rsp_data_in.temperature_tenths = s12_temp_ff;
         if (fin_p[31]) begin
            rsp_data_in.pressure_pa = '0;
         end else if (fin_p > {14'd0, bpc_pkg::PRESS_MAX}) begin
            rsp_data_in.pressure_pa = bpc_pkg::PRESS_MAX;
         end else begin
            rsp_data_in.pressure_pa = fin_p[17:0];
         end
      end
   end

   // ---------------- pipeline registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
         s11_valid_ff <= 1'b0;
         s12_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s4_valid_ff  <= da_out.valid;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         s8_valid_ff  <= s7_valid_ff;
         s9_valid_ff  <= s8_valid_ff;
         s10_valid_ff <= db_out.valid;
         s11_valid_ff <= s10_valid_ff;
         s12_valid_ff <= s11_valid_ff;
         rsp_valid_ff <= s12_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ut_ff     <= {req_data.temp_high_byte, req_data.temp_low_byte};
         s1_up_ff     <= up_shift[bpc_pkg::UP_WIDTH-1:0];

         s2_x1_ff     <= 32'($signed(s2_prod) >>> 15);
         s2_up_ff     <= s1_up_ff;

         s4_fault_ff  <= da_out.fault;
         s4_up_ff     <= da_out.up;
         s4_temp_ff   <= s4_temp_sat;
         s4_b6_ff     <= s4_b5 - bpc_pkg::B6_OFFSET;

         s5_fault_ff  <= s4_fault_ff;
         s5_up_ff     <= s4_up_ff;
         s5_temp_ff   <= s4_temp_ff;
         s5_b6sq_ff   <= 32'($signed(s5_sq) >>> 12);
         s5_x2a_ff    <= 32'($signed(s5_p2) >>> 11);
         s5_x1b_ff    <= 32'($signed(s5_p3) >>> 13);

         s6_fault_ff  <= s5_fault_ff;
         s6_up_ff     <= s5_up_ff;
         s6_temp_ff   <= s5_temp_ff;
         s6_x1a_ff    <= 32'($signed(s6_pa) >>> 11);
         s6_x2a_ff    <= s5_x2a_ff;
         s6_x1b_ff    <= s5_x1b_ff;
         s6_x2b_ff    <= 32'($signed(s6_pb) >>> 16);

         s7_fault_ff  <= s6_fault_ff;
         s7_up_ff     <= s6_up_ff;
         s7_temp_ff   <= s6_temp_ff;
         s7_b3_ff     <= 32'($signed(s7_sum + 32'd2) >>> 2);
         s7_x3_ff     <= 32'($signed(s6_x1b_ff + s6_x2b_ff + 32'd2) >>> 2);

         s8_fault_ff  <= s7_fault_ff;
         s8_temp_ff   <= s7_temp_ff;
         s8_b4_ff     <= s8_b4p >> 15;
         s8_diff_ff   <= {13'd0, s7_up_ff} - s7_b3_ff;

         s9_fault_ff  <= s8_fault_ff;
         s9_temp_ff   <= s8_temp_ff;
         s9_b7_ff     <= s9_b7;
         s9_b4_ff     <= s8_b4_ff;

         s10_fault_ff <= db_out.fault;
         s10_temp_ff  <= db_out.temp;
         s10_p_ff     <= db_out.big ? (db_q << 1) : db_q;

         s11_fault_ff <= s10_fault_ff;
         s11_temp_ff  <= s10_temp_ff;
         s11_p_ff     <= s10_p_ff;
         s11_sq_ff    <= s11_ps * s11_ps;
         s11_x2_ff    <= 32'($signed(s11_x2p) >>> 16);

         s12_fault_ff <= s11_fault_ff;
         s12_temp_ff  <= s11_temp_ff;
         s12_p_ff     <= s11_p_ff;
         s12_x1_ff    <= 32'($signed(s12_prod) >>> 16);
         s12_x2_ff    <= s11_x2_ff;

         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // a faulted transaction carries zero values
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_fault |->
         rsp_data.temperature_tenths == 16'sd0 && rsp_data.pressure_pa == 18'd0)
      else $error("fault result with nonzero values");

   // reset empties the output register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a held pipe keeps its waiting result
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> rsp_valid_ff)
      else $error("waiting result lost while pipe held");

   // a held pipe takes no new transaction into stage 1
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(s1_valid_ff))
      else $error("stage 1 moved while pipe held");
`endif

endmodule
`default_nettype wire

[rtl/bpc_div.sv]
// Pipelined 32-bit unsigned divider, one quotient bit per stage, with sideband.
`default_nettype none
module bpc_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                enable,
   input  wire logic [31:0]         num,
   input  wire logic [31:0]         den,
   input  wire bpc_pkg::side_type   side,
   output logic [31:0]              quotient,
   output bpc_pkg::side_type        side_out
);

   logic [31:0]       rem_ff  [bpc_pkg::DIV_STAGES];
   logic [31:0]       num_ff  [bpc_pkg::DIV_STAGES];
   logic [31:0]       den_ff  [bpc_pkg::DIV_STAGES];
   bpc_pkg::side_type side_ff [bpc_pkg::DIV_STAGES];

   logic [31:0]       rem_in  [bpc_pkg::DIV_STAGES];
   logic [31:0]       num_in  [bpc_pkg::DIV_STAGES];

   always_comb begin
      for (int k = 0; k < bpc_pkg::DIV_STAGES; k++) begin
         logic [31:0] rp;
         logic [31:0] np;
         logic [31:0] dp;
         logic [32:0] trial;
         logic        ge;
         rp = (k == 0) ? 32'd0 : rem_ff[(k == 0) ? 0 : k-1];
         np = (k == 0) ? num   : num_ff[(k == 0) ? 0 : k-1];
         dp = (k == 0) ? den   : den_ff[(k == 0) ? 0 : k-1];
         trial = {rp, np[31]};
         ge = (trial >= {1'b0, dp});
         rem_in[k] = ge ? 32'(trial - {1'b0, dp}) : trial[31:0];
         num_in[k] = {np[30:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < bpc_pkg::DIV_STAGES; k++) begin
            side_ff[k].valid <= 1'b0;
         end
      end else if (enable) begin
         for (int k = 0; k < bpc_pkg::DIV_STAGES; k++) begin
            rem_ff[k]  <= rem_in[k];
            num_ff[k]  <= num_in[k];
            den_ff[k]  <= (k == 0) ? den : den_ff[(k == 0) ? 0 : k-1];
            side_ff[k] <= (k == 0) ? side : side_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   assign quotient = num_ff[bpc_pkg::DIV_STAGES-1];
   assign side_out = side_ff[bpc_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

[dv/tb_barometric_pressure_compensation_unit.sv]
// Testbench for the barometric pressure compensation unit: directed table plus random readings.
`default_nettype none
module tb_barometric_pressure_compensation_unit;
   timeunit 1ns;
   timeprecision 1ps;

   // pipeline depth from accept to result, plus slack for the drain waits
   localparam int PIPE_DEPTH  = 76;
   localparam int DRAIN_WAIT  = PIPE_DEPTH + 24;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 190;
   localparam int IDLE_PCT    = 37;
   // indexes past the register list; writes there must be ignored
   localparam logic [2:0] REG_UNUSED_LO = bpc_pkg::REG_OSS + 3'd1;
   localparam logic [2:0] REG_UNUSED_HI = bpc_pkg::REG_OSS + 3'd2;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   bpc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   bpc_pkg::rsp_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   barometric_pressure_compensation_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow copy of the calibration registers, indexed like the block's
   logic [31:0]      cal_shadow [0:5];
   bpc_pkg::rsp_type pending_results [$];
   int               mismatches = 0;
   bit               idle_enable = 1'b1;
   int               hold_token = 0;

   function automatic logic [31:0] sra32(input logic [31:0] v, input int s);
      return $unsigned($signed(v) >>> s);
   endfunction

   function automatic logic [31:0] half_signed(input logic [15:0] h);
      return {{16{h[15]}}, h};
   endfunction

   // signed divide that truncates toward zero, done on magnitudes
   function automatic logic [31:0] div_trunc(input logic [31:0] n, input logic [31:0] d);
      logic [31:0] an, ad, q;
      an = n[31] ? -n : n;
      ad = d[31] ? -d : d;
      q  = an / ad;
      return (n[31] != d[31]) ? -q : q;
   endfunction

   // integer compensation of one reading under the current calibration
   function automatic bpc_pkg::rsp_type compensate(input bpc_pkg::req_type r);
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, b6sq, p, t;
      logic [1:0]  oss;
      bpc_pkg::rsp_type res;
      ac1 = half_signed(cal_shadow[bpc_pkg::REG_AC1_AC2][31:16]);
      ac2 = half_signed(cal_shadow[bpc_pkg::REG_AC1_AC2][15:0]);
      ac3 = half_signed(cal_shadow[bpc_pkg::REG_AC3_AC4][31:16]);
      ac4 = {16'd0, cal_shadow[bpc_pkg::REG_AC3_AC4][15:0]};
      ac5 = {16'd0, cal_shadow[bpc_pkg::REG_AC5_AC6][31:16]};
      ac6 = {16'd0, cal_shadow[bpc_pkg::REG_AC5_AC6][15:0]};
      b1  = half_signed(cal_shadow[bpc_pkg::REG_B1_B2][31:16]);
      b2  = half_signed(cal_shadow[bpc_pkg::REG_B1_B2][15:0]);
      mc  = half_signed(cal_shadow[bpc_pkg::REG_MC_MD][31:16]);
      md  = half_signed(cal_shadow[bpc_pkg::REG_MC_MD][15:0]);
      oss = cal_shadow[bpc_pkg::REG_OSS][1:0];
      res = '{temperature_tenths: '0, pressure_pa: '0, divide_fault: 1'b1};
      ut = {16'd0, r.temp_high_byte, r.temp_low_byte};
      up = {8'd0, r.press_high_byte, r.press_mid_byte, r.press_extra_byte} >> (8 - oss);
      x1 = sra32((ut - ac6) * ac5, 15);
      x2 = x1 + md;
      if (x2 == 0) return res;
      x2 = div_trunc(mc << 11, x2);
      b5 = x1 + x2;
      t  = sra32(b5 + 32'd8, 4);
      b6 = b5 - 32'd4000;
      b6sq = sra32(b6 * b6, 12);
      x1 = sra32(b2 * b6sq, 11);
      x2 = sra32(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = sra32(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
      x1 = sra32(ac3 * b6, 13);
      x2 = sra32(b1 * b6sq, 16);
      x3 = sra32(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + 32'd32768)) >> 15;
      if (b4 == 0) return res;
      b7 = (up - b3) * (32'd50000 >> oss);
      if (!b7[31]) p = (b7 * 32'd2) / b4;
      else p = (b7 / b4) * 32'd2;
      x1 = sra32(p, 8);
      x1 = x1 * x1;
      x1 = sra32(x1 * 32'd3038, 16);
      x2 = sra32(32'hFFFF_E343 * p, 16);
      p  = p + sra32(x1 + x2 + 32'd3791, 4);
      // saturate both outputs to their field ranges
      if ($signed(t) < -32768) res.temperature_tenths = 16'sh8000;
      else if ($signed(t) > 32767) res.temperature_tenths = 16'sh7FFF;
      else res.temperature_tenths = t[15:0];
      if ($signed(p) < 0) res.pressure_pa = '0;
      else if ($signed(p) > 262143) res.pressure_pa = bpc_pkg::PRESS_MAX;
      else res.pressure_pa = p[17:0];
      res.divide_fault = 1'b0;
      return res;
   endfunction

   // Result side: check each accepted transaction against the oldest expectation,
   // then decide the next cycle's stall. A hold request pins stall high for a
   // long stretch so the pipe fills and pushes back on req_stall.
   int hold_left = 0;
   int hold_seen = 0;
   always @(posedge clock) begin
      bpc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %p", rsp_data);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.temperature_tenths !== want.temperature_tenths ||
                rsp_data.pressure_pa !== want.pressure_pa ||
                rsp_data.divide_fault !== want.divide_fault) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected t=%0d p=%0d f=%0b, got t=%0d p=%0d f=%0b",
                           want.temperature_tenths, want.pressure_pa, want.divide_fault,
                           rsp_data.temperature_tenths, rsp_data.pressure_pa,
                           rsp_data.divide_fault);
            end
         end
      end
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_enable && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // hold the enable high across a batch; the caller drops it afterwards
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == bpc_pkg::REG_OSS) cal_shadow[idx] = val & 32'd3;
      else if (idx < REG_UNUSED_LO) cal_shadow[idx] = val;
      @(posedge clock);
   endtask

   // drain every pending transaction, then load a full calibration set
   task automatic load_calibration(input logic [31:0] w0, w1, w2, w3, w4, w5);
      wait (pending_results.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_write(bpc_pkg::REG_AC1_AC2, w0);
      csr_write(bpc_pkg::REG_AC3_AC4, w1);
      csr_write(bpc_pkg::REG_AC5_AC6, w2);
      csr_write(bpc_pkg::REG_B1_B2, w3);
      csr_write(bpc_pkg::REG_MC_MD, w4);
      csr_write(bpc_pkg::REG_OSS, w5);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // offer one reading, record its expectation when accepted
   task automatic send_reading(input bpc_pkg::req_type r);
      while (idle_enable && ($urandom_range(99) < IDLE_PCT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(compensate(r));
   endtask

   function automatic bpc_pkg::req_type random_reading();
      return bpc_pkg::req_type'({$urandom, 8'($urandom)});
   endfunction

   typedef struct {
      bpc_pkg::req_type reading;
      bit               typed;      // expected result written in below
      bpc_pkg::rsp_type result;
   } stim_row;

   localparam bpc_pkg::rsp_type ZERO_FAULT = '{temperature_tenths: '0, pressure_pa: '0,
                                              divide_fault: 1'b1};
   localparam bpc_pkg::rsp_type NO_CHECK = '0;

   // First four rows run on reset calibration, where every divisor is zero;
   // the rest run on a typical factory set and go through the predictor.
   stim_row directed [] = '{
      '{40'h00_00_00_00_00, 1'b1, ZERO_FAULT},
      '{40'hFF_FF_FF_FF_FF, 1'b1, ZERO_FAULT},
      '{40'h6C_FA_5D_23_00, 1'b1, ZERO_FAULT},
      '{40'h80_00_80_00_80, 1'b1, ZERO_FAULT},
      '{40'h6C_FA_5D_23_00, 1'b0, NO_CHECK},
      '{40'h00_00_00_00_00, 1'b0, NO_CHECK},
      '{40'hFF_FF_FF_FF_FF, 1'b0, NO_CHECK},
      '{40'hFF_FF_00_00_00, 1'b0, NO_CHECK},
      '{40'h00_00_FF_FF_FF, 1'b0, NO_CHECK},
      '{40'h80_00_80_00_00, 1'b0, NO_CHECK},
      '{40'h7F_FF_7F_FF_FF, 1'b0, NO_CHECK},
      '{40'h5A_A5_A5_5A_A5, 1'b0, NO_CHECK},
      '{40'h00_01_00_00_01, 1'b0, NO_CHECK}
   };

   initial begin
      int i;
      for (i = 0; i < 6; i++) cal_shadow[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows on reset calibration: typed expectations
      for (i = 0; i < 4; i++) begin
         send_reading(directed[i].reading);
         pending_results[pending_results.size() - 1] = directed[i].result;
      end
      req_valid <= 1'b0;

      // typical factory calibration; also poke the unused indexes
      load_calibration({16'sd408, -16'sd72}, {-16'sd14383, 16'd32741},
                       {16'd32757, 16'd23153}, {16'sd6190, 16'sd4},
                       {-16'sd8711, 16'sd2868}, 32'd0);
      csr_write(REG_UNUSED_LO, $urandom);
      csr_write(REG_UNUSED_HI, $urandom);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      for (i = 4; i < directed.size(); i++) send_reading(directed[i].reading);
      for (i = 0; i < PHASE_ITEMS; i++) send_reading(random_reading());
      req_valid <= 1'b0;

      // highest oversampling; receiver holds off while readings keep coming
      load_calibration({16'sd408, -16'sd72}, {-16'sd14383, 16'd32741},
                       {16'd32757, 16'd23153}, {16'sd6190, 16'sd4},
                       {-16'sd8711, 16'sd2868}, 32'hFFFF_FFFF);
      hold_token++;
      for (i = 0; i < PHASE_ITEMS; i++) send_reading(random_reading());
      req_valid <= 1'b0;

      // extremes of every register
      load_calibration('1, '1, '1, '1, '1, 32'd1);
      for (i = 0; i < PHASE_ITEMS; i++) send_reading(random_reading());
      req_valid <= 1'b0;
      load_calibration(32'h7FFF_7FFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_7FFF,
                       32'h7FFF_7FFF, 32'd2);
      for (i = 0; i < PHASE_ITEMS; i++) send_reading(random_reading());
      req_valid <= 1'b0;
      load_calibration(32'h8000_8000, 32'h8000_0001, 32'h0001_0000, 32'h8000_8000,
                       32'h8000_8000, 32'd3);
      for (i = 0; i < PHASE_ITEMS; i++) send_reading(random_reading());
      req_valid <= 1'b0;

      // zero AC4 forces the pressure divisor to zero
      load_calibration({16'sd408, -16'sd72}, 32'hC7D1_0000, {16'd32757, 16'd23153},
                       {16'sd6190, 16'sd4}, {-16'sd8711, 16'sd2868}, 32'd1);
      for (i = 0; i < 20; i++) send_reading(random_reading());
      req_valid <= 1'b0;

      // random calibration; one phase runs back to back with no idling
      for (int ph = 0; ph < 4; ph++) begin
         load_calibration($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         idle_enable = (ph != 1);
         for (i = 0; i < PHASE_ITEMS; i++) send_reading(random_reading());
         req_valid <= 1'b0;
      end
      idle_enable = 1'b1;

      wait (pending_results.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

endmodule
`default_nettype wire

[barometric_pressure_compensation_unit.f]
rtl/bpc_pkg.sv
rtl/bpc_div.sv
rtl/barometric_pressure_compensation_unit.sv
dv/tb_barometric_pressure_compensation_unit.sv
